// File: rtl/block_aligned_range_partition_macros.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef BLOCK_ALIGNED_RANGE_PARTITION_MACROS_SVH
`define BLOCK_ALIGNED_RANGE_PARTITION_MACROS_SVH
`ifndef SYNTHESIS
`define BAR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define BAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BAR_ASSERT_SAME(lbl, ante, cons)
`define BAR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/bar_pkg.sv
// Shared types and constants of the block-aligned range partitioner.
package bar_pkg;
  localparam int LEN_W       = 32;
  localparam int BF_W        = 16;
  localparam int ID_W        = 8;
  localparam int WC_W        = 9;
  localparam int MAX_WORKERS = 256;
  localparam int DIV_STAGES  = LEN_W;
  localparam int ADDR_W      = 3;
  localparam logic [ADDR_W-1:0] REG_WC_ADDR = 3'd0;

  typedef struct packed {
    logic [BF_W-1:0] bf;
    logic [BF_W-1:0] left;
    logic            low;
    logic [ID_W-1:0] id;
    logic [WC_W-1:0] ways;
    logic            inval;
  } side_t;
endpackage

// File: rtl/bar_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module bar_div import bar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [LEN_W-1:0]  dividend,
  input  logic [BF_W-1:0]   divisor,
  input  side_t             in_side,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LEN_W-1:0]  quotient,
  output logic [BF_W-1:0]   remainder,
  output side_t             out_side
);
  logic [DIV_STAGES:1] vld;
  logic [DIV_STAGES:1] rdy;
  logic [LEN_W-1:0]    word [DIV_STAGES:1];
  logic [BF_W-1:0]     rem  [DIV_STAGES:1];
  logic [BF_W-1:0]     dvs  [DIV_STAGES:1];
  side_t               sd   [DIV_STAGES:1];

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    logic             pv;
    logic [LEN_W-1:0] pword;
    logic [BF_W-1:0]  prem;
    logic [BF_W-1:0]  pdvs;
    side_t            psd;
    logic [BF_W:0]    trial;
    logic             ge;

    if (s == 1) begin : g_first
      assign pv    = in_valid;
      assign pword = dividend;
      assign prem  = '0;
      assign pdvs  = divisor;
      assign psd   = in_side;
    end else begin : g_rest
      assign pv    = vld[s-1];
      assign pword = word[s-1];
      assign prem  = rem[s-1];
      assign pdvs  = dvs[s-1];
      assign psd   = sd[s-1];
    end

    if (s == DIV_STAGES) begin : g_last
      assign rdy[s] = !vld[s] || !out_stall;
    end else begin : g_mid
      assign rdy[s] = !vld[s] || rdy[s+1];
    end

    assign trial = {prem, pword[LEN_W-1]};
    assign ge    = trial >= {1'b0, pdvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && pv) begin
        word[s] <= {pword[LEN_W-2:0], ge};
        rem[s]  <= ge ? BF_W'(trial - {1'b0, pdvs}) : trial[BF_W-1:0];
        dvs[s]  <= pdvs;
        sd[s]   <= psd;
      end
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[DIV_STAGES];
  assign quotient  = word[DIV_STAGES];
  assign remainder = rem[DIV_STAGES];
  assign out_side  = sd[DIV_STAGES];
endmodule

// File: rtl/bar_map.sv
// Three-stage mapper from block counts to a worker's start and end.
module bar_map import bar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [LEN_W-1:0] per,
  input  logic [WC_W-1:0]  extra,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LEN_W-1:0] range_start,
  output logic [LEN_W-1:0] range_end,
  output logic             index_invalid
);
  logic va, vb, vc;
  logic rdy_a, rdy_b, rdy_c;

  // Stage A: part sizes.
  logic [LEN_W-1:0] small_a, big_a;
  logic [WC_W-1:0]  extra_a, nsmall_a;
  side_t            sd_a;
  logic [LEN_W-1:0] small_n;

  // Stage B: products.
  logic [LEN_W-1:0] pa, pb, pc, pd, pf, pg;
  logic [LEN_W-1:0] small_b, big_b;
  logic [WC_W-1:0]  extra_b, nsmall_b;
  side_t            sd_b;
  logic [WC_W-1:0]  id_a9;

  // Stage C: sums.
  logic [WC_W-1:0]  id_b9;
  logic [LEN_W-1:0] left_b;
  logic [LEN_W-1:0] st_n, en_n, mid;
  logic             lt_ex, lt_ns, is_last;

  assign rdy_c    = !vc || !out_stall;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_stall = !rdy_a;

  assign small_n = LEN_W'(per * LEN_W'(in_side.bf));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= in_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
      if (rdy_c) begin
        vc <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      small_a  <= small_n;
      big_a    <= small_n + ((extra != '0) ? LEN_W'(in_side.bf) : '0);
      extra_a  <= extra;
      nsmall_a <= in_side.ways - extra;
      sd_a     <= in_side;
    end
  end

  assign id_a9 = {1'b0, sd_a.id};

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      pa       <= LEN_W'(big_a * LEN_W'(id_a9));
      pb       <= LEN_W'(big_a * LEN_W'(extra_a));
      pc       <= LEN_W'(small_a * LEN_W'(WC_W'(id_a9 - extra_a)));
      pd       <= LEN_W'(small_a * LEN_W'(id_a9));
      pf       <= LEN_W'(small_a * LEN_W'(nsmall_a));
      pg       <= LEN_W'(big_a * LEN_W'(WC_W'(id_a9 - nsmall_a)));
      small_b  <= small_a;
      big_b    <= big_a;
      extra_b  <= extra_a;
      nsmall_b <= nsmall_a;
      sd_b     <= sd_a;
    end
  end

  assign id_b9   = {1'b0, sd_b.id};
  assign left_b  = LEN_W'(sd_b.left);
  assign lt_ex   = id_b9 < extra_b;
  assign lt_ns   = id_b9 < nsmall_b;
  assign is_last = id_b9 == WC_W'(sd_b.ways - 1'b1);

  always_comb begin
    mid = '0;
    if (!sd_b.low) begin
      if (lt_ex) begin
        st_n = pa;
        en_n = pa + big_b;
      end else begin
        st_n = pb + pc;
        en_n = pb + pc + small_b + (is_last ? left_b : '0);
      end
    end else begin
      if (lt_ns) begin
        st_n = pd + ((sd_b.id != '0) ? left_b : '0);
        en_n = pd + small_b + left_b;
      end else begin
        mid  = pf + left_b + pg;
        st_n = mid;
        en_n = mid + big_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb) begin
      range_start   <= sd_b.inval ? '0 : st_n;
      range_end     <= sd_b.inval ? '0 : en_n;
      index_invalid <= sd_b.inval;
    end
  end

  assign out_valid = vc;
endmodule

// File: rtl/block_aligned_range_partition.sv
// Top level of the block-aligned range partitioner with its register port.
// Each request names a worker and returns its [range_start, range_end) of a
// block-aligned, balanced split of 0..total_length over worker_count workers (at most 256).
// One request is taken per clock while req_stall is low; results leave in order,
// one per cycle while rsp_stall is low, through 32 stages of the length-by-block
// divider, 32 stages of the blocks-by-workers divider and 3 stages of multiply and add.
// A stalled result holds only the stages behind it; empty stages still fill.
// worker_count sits at byte address 0 and resets to 1.
`include "block_aligned_range_partition_macros.svh"
module block_aligned_range_partition import bar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [LEN_W-1:0]  total_length,
  input  logic [BF_W-1:0]   block_size,
  input  logic              edge_low,
  input  logic [ID_W-1:0]   worker_index,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [LEN_W-1:0]  range_start,
  output logic [LEN_W-1:0]  range_end,
  output logic              index_invalid
);
  logic [WC_W-1:0]  worker_count;
  logic [WC_W-1:0]  ways_sat;
  logic             cfg_wr;
  side_t            side_in, side1, side2, side2_in;
  logic             v1, s1, v2, s2;
  logic [LEN_W-1:0] q1, q2;
  logic [BF_W-1:0]  r1, r2;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr == REG_WC_ADDR;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= WC_W'(1);
    end else if (cfg_wr) begin
      worker_count <= pwdata[WC_W-1:0];
    end
  end

  assign prdata = (paddr == REG_WC_ADDR) ? 32'(worker_count) : '0;

  assign ways_sat = (worker_count > WC_W'(MAX_WORKERS)) ? WC_W'(MAX_WORKERS)
                                                         : worker_count;

  always_comb begin
    side_in.bf    = (block_size == '0) ? BF_W'(1) : block_size;
    side_in.left  = '0;
    side_in.low   = edge_low;
    side_in.id    = worker_index;
    // A zero count makes every index invalid; the divisor just must not be zero.
    side_in.ways  = (ways_sat == '0) ? WC_W'(1) : ways_sat;
    side_in.inval = {1'b0, worker_index} >= ways_sat;
  end

  bar_div u_div_blocks (
    .clk(clk), .rst(rst),
    .in_valid(req_valid), .in_stall(req_stall),
    .dividend(total_length), .divisor(side_in.bf), .in_side(side_in),
    .out_valid(v1), .out_stall(s1),
    .quotient(q1), .remainder(r1), .out_side(side1)
  );

  always_comb begin
    side2_in      = side1;
    side2_in.left = r1;
  end

  bar_div u_div_workers (
    .clk(clk), .rst(rst),
    .in_valid(v1), .in_stall(s1),
    .dividend(q1), .divisor(BF_W'(side1.ways)), .in_side(side2_in),
    .out_valid(v2), .out_stall(s2),
    .quotient(q2), .remainder(r2), .out_side(side2)
  );

  bar_map u_map (
    .clk(clk), .rst(rst),
    .in_valid(v2), .in_stall(s2),
    .per(q2), .extra(r2[WC_W-1:0]), .in_side(side2),
    .out_valid(rsp_valid), .out_stall(rsp_stall),
    .range_start(range_start), .range_end(range_end),
    .index_invalid(index_invalid)
  );

  `BAR_ASSERT_SAME(a_invalid_zero, rsp_valid && index_invalid, range_start == '0 && range_end == '0)
  `BAR_ASSERT_NEXT(a_wc_write, cfg_wr, worker_count == $past(pwdata[WC_W-1:0]))
  `BAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable({range_start, range_end}))
endmodule

// File: dv/block_aligned_range_partition_test.sv
// Self-checking testbench for the block-aligned range partitioner.
`timescale 1ns / 1ps
module block_aligned_range_partition_test;
  import bar_pkg::*;

  localparam int LATENCY = 67;

  typedef struct packed {
    logic [LEN_W-1:0] start_idx;
    logic [LEN_W-1:0] end_idx;
    logic             bad;
  } span_t;

  typedef struct {
    logic [LEN_W-1:0] len;
    logic [BF_W-1:0]  bf;
    logic             low;
    logic [ID_W-1:0]  id;
    bit               known;
    span_t            want;
  } query_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic req_valid, req_stall;
  logic [LEN_W-1:0] total_length;
  logic [BF_W-1:0] block_size;
  logic edge_low;
  logic [ID_W-1:0] worker_index;
  logic rsp_valid, rsp_stall;
  logic [LEN_W-1:0] range_start, range_end;
  logic index_invalid;

  block_aligned_range_partition u_dut (.*);

  logic [WC_W-1:0] ways_cfg;
  span_t spans_due[$];
  int errors;
  bit sink_idle_on;
  bit hold_sink;
  int hold_cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  // Works out one worker's subrange from the current worker count.
  function automatic span_t partition_span(logic [LEN_W-1:0] len, logic [BF_W-1:0] bfi,
                                           logic low, logic [ID_W-1:0] id);
    logic [63:0] ways, bf, whole, left, per, extra, big, little, base, nsmall;
    logic [63:0] s, e;
    span_t r;
    ways = ways_cfg > MAX_WORKERS ? MAX_WORKERS : ways_cfg;
    bf = (bfi == 0) ? 1 : bfi;
    r = '0;
    if (id >= ways) begin
      r.bad = 1'b1;
      return r;
    end
    whole = len / bf;
    left = len % bf;
    per = whole / ways;
    extra = whole % ways;
    big = (per + (extra != 0)) * bf;
    little = per * bf;
    if (!low) begin
      base = extra * big;
      if (id < extra) begin
        s = id * big;
        e = (id + 1) * big;
      end else begin
        s = base + (id - extra) * little;
        e = base + (id - extra + 1) * little;
        if (id == ways - 1) e += left;
      end
    end else begin
      nsmall = ways - extra;
      base = nsmall * little + left;
      if (id < nsmall) begin
        s = id * little + ((id != 0) ? left : 0);
        e = (id + 1) * little + left;
      end else begin
        s = base + (id - nsmall) * big;
        e = base + (id - nsmall + 1) * big;
      end
    end
    r.start_idx = s[31:0];
    r.end_idx = e[31:0];
    return r;
  endfunction

  task automatic write_ways(logic [WC_W-1:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_WC_ADDR; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    ways_cfg = v;
  endtask

  task automatic drain();
    int n;
    n = 0;
    req_valid <= 0;
    while (spans_due.size() != 0) @(posedge clk);
    while (n < LATENCY + 5) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Offers one beat; the expectation is queued at the accepting edge.
  task automatic send(query_t q, bit gaps);
    span_t p;
    int g;
    if (gaps && $urandom_range(0, 5) == 0) begin
      g = $urandom_range(1, 9);
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
    p = partition_span(q.len, q.bf, q.low, q.id);
    if (q.known && p != q.want) begin
      $display("%0t table row disagrees: expected %h predicted %h", $time, q.want, p);
      errors++;
    end
    req_valid <= 1;
    total_length <= q.len; block_size <= q.bf; edge_low <= q.low; worker_index <= q.id;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    spans_due.push_back(q.known ? q.want : p);
  endtask

  // Mostly valid worker indexes, sometimes out of range.
  function automatic query_t rand_query();
    query_t q;
    int k;
    k = $urandom_range(0, 3);
    q.len = (k == 0) ? $urandom_range(0, 300) : $urandom;
    q.bf = (k == 1) ? BF_W'($urandom) : BF_W'($urandom_range(0, 40));
    q.low = 1'($urandom_range(0, 1));
    q.id = ($urandom_range(0, 7) == 0 || ways_cfg == 0) ? ID_W'($urandom)
         : ID_W'($urandom_range(0, (ways_cfg > 256 ? 256 : ways_cfg) - 1));
    q.known = 0;
    return q;
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (spans_due.size() == 0) begin
        $display("%0t unexpected result %h %h %b", $time, range_start, range_end,
                 index_invalid);
        errors++;
      end else begin
        span_t w;
        w = spans_due.pop_front();
        if (range_start !== w.start_idx) begin
          $display("%0t range_start expected %h actual %h", $time, w.start_idx, range_start);
          errors++;
        end
        if (range_end !== w.end_idx) begin
          $display("%0t range_end expected %h actual %h", $time, w.end_idx, range_end);
          errors++;
        end
        if (index_invalid !== w.bad) begin
          $display("%0t index_invalid expected %b actual %b", $time, w.bad, index_invalid);
          errors++;
        end
      end
    end
  end

  // Receiver stalls: random bursts, or one long hold when asked.
  initial begin
    int g;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        rsp_stall <= 1;
        repeat (hold_cycles) @(posedge clk);
        rsp_stall <= 0;
        hold_sink = 0;
      end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
        g = $urandom_range(1, 9);
        rsp_stall <= 1;
        repeat (g) @(posedge clk);
        rsp_stall <= 0;
      end
    end
  end

  initial begin
    query_t dir[$];
    logic [WC_W-1:0] settings[6];
    errors = 0;
    ways_cfg = 1;
    sink_idle_on = 0;
    hold_sink = 0;
    hold_cycles = 300;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req_valid = 0; total_length = '0; block_size = '0; edge_low = 0; worker_index = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Rows after reset: one worker owns the whole range.
    dir.push_back('{32'd100, 16'd7, 1'b0, 8'd0, 1, '{32'd0, 32'd100, 1'b0}});
    dir.push_back('{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'd0, 1, '{0, 32'hFFFF_FFFF, 1'b0}});
    dir.push_back('{32'd5, 16'd0, 1'b0, 8'd0, 1, '{32'd0, 32'd5, 1'b0}});
    dir.push_back('{32'd0, 16'd1, 1'b1, 8'd0, 1, '{32'd0, 32'd0, 1'b0}});
    dir.push_back('{32'd9, 16'd2, 1'b0, 8'd1, 1, '{32'd0, 32'd0, 1'b1}});
    dir.push_back('{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 8'hFF, 1, '{32'd0, 32'd0, 1'b1}});
    foreach (dir[i]) send(dir[i], 0);
    drain();

    // Four workers, fewer blocks than workers and then more, leftover on each edge.
    write_ways(9'd4);
    dir.delete();
    dir.push_back('{32'd10, 16'd3, 1'b0, 8'd0, 1, '{32'd0, 32'd3, 1'b0}});
    dir.push_back('{32'd10, 16'd3, 1'b0, 8'd3, 1, '{32'd9, 32'd10, 1'b0}});
    dir.push_back('{32'd10, 16'd3, 1'b1, 8'd0, 1, '{32'd0, 32'd1, 1'b0}});
    dir.push_back('{32'd10, 16'd3, 1'b1, 8'd3, 1, '{32'd7, 32'd10, 1'b0}});
    dir.push_back('{32'd10, 16'd3, 1'b1, 8'd4, 1, '{32'd0, 32'd0, 1'b1}});
    for (int i = 0; i < 4; i++) dir.push_back('{32'd23, 16'd2, i[0], 8'(i), 0, '0});
    foreach (dir[i]) send(dir[i], 0);
    drain();

    // Zero workers: everything invalid.
    write_ways(9'd0);
    send('{32'd50, 16'd5, 1'b0, 8'd0, 1, '{32'd0, 32'd0, 1'b1}}, 0);
    drain();
    // Count above the worker limit saturates.
    write_ways(9'h1FF);
    send('{32'hFFFF_FFFF, 16'h1, 1'b0, 8'hFF, 0, '0}, 0);
    send('{32'h8000_0000, 16'h8000, 1'b1, 8'h80, 0, '0}, 0);
    send('{32'h1234_5678, 16'h00FF, 1'b0, 8'h7F, 0, '0}, 0);
    drain();

    // Receiver holds off long while the sender keeps offering.
    write_ways(9'd7);
    hold_sink = 1;
    for (int i = 0; i < 120; i++) send(rand_query(), 0);
    drain();

    sink_idle_on = 1;
    settings = '{9'd1, 9'd256, 9'd3, 9'd16, 9'd100, 9'd2};
    foreach (settings[s]) begin
      write_ways(settings[s]);
      for (int i = 0; i < 150; i++) send(rand_query(), 1);
      req_valid <= 0;
      drain();
    end
    // Final stretch without idling.
    sink_idle_on = 0;
    write_ways(9'd5);
    for (int i = 0; i < 100; i++) send(rand_query(), 0);
    req_valid <= 0;
    drain();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
